>>> rtl/fdt_pkg.sv
`default_nettype none
package fdt_pkg;
	localparam int unsigned VALUE_BITS = 31;
	localparam int unsigned CNT_BITS = $clog2(VALUE_BITS + 1);

	typedef logic [VALUE_BITS-1:0] value_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DIVWAIT,
		ST_DECIDE,
		ST_LEG,
		ST_LEGWAIT,
		ST_LEGDECIDE,
		ST_NEXT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		DV_REST_CAND,
		DV_Q_CAND,
		DV_REST_BOUND
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_factor;
		logic     leg_init;
		logic     leg_accum;
		logic     next_cand;
		logic     use_rest;
		logic     fail;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic rest_is_one;
		logic rest_gt_one;
		logic cand_ok;
		logic rem_zero;
		logic leg_more;
		logic leg_met;
		logic divisor_zero;
		logic exp_nonzero;
	} sts_t;
endpackage
`default_nettype wire

>>> rtl/fdt_divider.sv
`default_nettype none
module fdt_divider (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  fdt_pkg::value_t      dividend,
	input  fdt_pkg::value_t      dvsr,
	output fdt_pkg::value_t      quot,
	output fdt_pkg::value_t      rem,
	output logic                 done
);
	localparam int unsigned VB = fdt_pkg::VALUE_BITS;
	fdt_pkg::value_t      q_q;
	fdt_pkg::value_t      d_q;
	logic [VB:0]          r_q;
	logic [fdt_pkg::CNT_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic [VB:0]          shifted;
	logic [VB:0]          diff;

	assign shifted = {r_q[VB-1:0], q_q[VB-1]};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= fdt_pkg::CNT_BITS'(VB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - fdt_pkg::CNT_BITS'(1);
				if (cnt_q == fdt_pkg::CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			d_q <= dvsr;
			r_q <= '0;
		end else if (busy_q) begin
			if (!diff[VB]) begin
				r_q <= diff;
				q_q <= {q_q[VB-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				q_q <= {q_q[VB-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q[VB-1:0];
endmodule
`default_nettype wire

>>> rtl/fdt_datapath.sv
`default_nettype none
module fdt_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  fdt_pkg::cmd_t       cmd,
	output fdt_pkg::sts_t       sts,
	input  fdt_pkg::value_t     factorial_arg,
	input  fdt_pkg::value_t     divisor,
	output logic                result
);
	fdt_pkg::value_t rest_q, cand_q, f_q, q_q, exp_q, cnt_q, p_q;
	logic            res_q;
	fdt_pkg::value_t dv_a, dv_b, quot, rem;
	logic            done;

	always_comb begin
		case (cmd.div_sel)
			fdt_pkg::DV_REST_CAND:  begin dv_a = rest_q; dv_b = cand_q; end
			fdt_pkg::DV_Q_CAND:     begin dv_a = q_q;    dv_b = p_q;    end
			fdt_pkg::DV_REST_BOUND: begin dv_a = rest_q; dv_b = cand_q; end
			default:                begin dv_a = rest_q; dv_b = cand_q; end
		endcase
	end

	fdt_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dv_a), .dvsr(dv_b), .quot(quot), .rem(rem), .done(done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= divisor;
			f_q    <= factorial_arg;
			cand_q <= fdt_pkg::value_t'(2);
			exp_q  <= '0;
			res_q  <= 1'b1;
		end
		if (cmd.take_factor) begin
			rest_q <= quot;
			exp_q  <= exp_q + fdt_pkg::value_t'(1);
		end
		if (cmd.leg_init) begin
			q_q   <= f_q;
			cnt_q <= '0;
			p_q   <= cmd.use_rest ? rest_q : cand_q;
			if (cmd.use_rest)
				exp_q <= fdt_pkg::value_t'(1);
		end
		if (cmd.leg_accum) begin
			q_q   <= quot;
			cnt_q <= cnt_q + quot;
		end
		if (cmd.next_cand) begin
			cand_q <= cand_q + fdt_pkg::value_t'(1);
			exp_q  <= '0;
		end
		if (cmd.fail)
			res_q <= 1'b0;
	end

	assign sts.div_done     = done;
	assign sts.rest_is_one  = rest_q == fdt_pkg::value_t'(1);
	assign sts.rest_gt_one  = rest_q > fdt_pkg::value_t'(1);
	assign sts.cand_ok      = cand_q <= quot;
	assign sts.rem_zero     = rem == '0;
	assign sts.leg_more     = (q_q >= p_q) && (cnt_q < exp_q);
	assign sts.leg_met      = cnt_q >= exp_q;
	assign sts.divisor_zero = rest_q == '0;
	assign sts.exp_nonzero  = exp_q != '0;
	assign result           = res_q;
endmodule
`default_nettype wire

>>> rtl/fdt_ctrl.sv
`default_nettype none
module fdt_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	output fdt_pkg::cmd_t   cmd,
	input  fdt_pkg::sts_t   sts
);
	fdt_pkg::state_t state_q, state_d;
	logic            use_rest_q, use_rest_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fdt_pkg::ST_IDLE;
			use_rest_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			use_rest_q <= use_rest_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		use_rest_d = use_rest_q;
		cmd        = '0;
		cmd.div_sel = fdt_pkg::DV_REST_CAND;
		in_stall   = 1'b1;
		out_valid  = 1'b0;
		case (state_q)
			fdt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = fdt_pkg::ST_CHECK;
				end
			end
			fdt_pkg::ST_CHECK: begin
				if (sts.divisor_zero) begin
					cmd.fail = 1'b1;
					state_d  = fdt_pkg::ST_OUT;
				end else if (sts.rest_is_one) begin
					state_d = fdt_pkg::ST_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = fdt_pkg::ST_DIVWAIT;
				end
			end
			fdt_pkg::ST_DIVWAIT: begin
				if (sts.div_done) begin
					if (!sts.exp_nonzero && !sts.cand_ok) begin
						if (sts.rest_gt_one) begin
							cmd.leg_init = 1'b1;
							cmd.use_rest = 1'b1;
							use_rest_d   = 1'b1;
							state_d      = fdt_pkg::ST_LEG;
						end else
							state_d = fdt_pkg::ST_OUT;
					end else
						state_d = fdt_pkg::ST_DECIDE;
				end
			end
			fdt_pkg::ST_DECIDE: begin
				if (sts.rem_zero) begin
					cmd.take_factor = 1'b1;
					state_d         = fdt_pkg::ST_DIV;
				end else if (sts.exp_nonzero) begin
					cmd.leg_init = 1'b1;
					use_rest_d   = 1'b0;
					state_d      = fdt_pkg::ST_LEG;
				end else begin
					cmd.next_cand = 1'b1;
					state_d       = fdt_pkg::ST_CHECK;
				end
			end
			fdt_pkg::ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = fdt_pkg::ST_DIVWAIT;
			end
			fdt_pkg::ST_LEG: begin
				if (sts.leg_more) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = fdt_pkg::DV_Q_CAND;
					state_d       = fdt_pkg::ST_LEGWAIT;
				end else
					state_d = fdt_pkg::ST_LEGDECIDE;
			end
			fdt_pkg::ST_LEGWAIT: begin
				cmd.div_sel = fdt_pkg::DV_Q_CAND;
				if (sts.div_done) begin
					cmd.leg_accum = 1'b1;
					state_d       = fdt_pkg::ST_LEG;
				end
			end
			fdt_pkg::ST_LEGDECIDE: begin
				if (!sts.leg_met) begin
					cmd.fail = 1'b1;
					state_d  = fdt_pkg::ST_OUT;
				end else if (use_rest_q)
					state_d = fdt_pkg::ST_OUT;
				else
					state_d = fdt_pkg::ST_NEXT;
			end
			fdt_pkg::ST_NEXT: begin
				cmd.next_cand = 1'b1;
				state_d       = fdt_pkg::ST_CHECK;
			end
			fdt_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall)
					state_d = fdt_pkg::ST_IDLE;
			end
			default: state_d = fdt_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/factorial_divisibility_test_top.sv
// One transaction at a time; each trial divisor or Legendre step uses the shared radix-2 divider.
// Divisor 0 or 1 is resolved without the divider; otherwise the run time is set by trial division
// up to the square root of the remaining divisor and by the Legendre steps.
// A new transaction can be taken in the cycle after the result is taken.
// Asynchronous active-low reset returns the controller to idle with no result pending.
`default_nettype none
module factorial_divisibility_test_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [fdt_pkg::VALUE_BITS-1:0]   factorial_arg,
	input  wire logic [fdt_pkg::VALUE_BITS-1:0]   divisor,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  divides
);
	fdt_pkg::cmd_t cmd;
	fdt_pkg::sts_t sts;

	fdt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	fdt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.factorial_arg(factorial_arg), .divisor(divisor), .result(divides)
	);
endmodule
`default_nettype wire

>>> rtl/fdt_checker.sv
`default_nettype none
module fdt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic divides
);
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(divides))
		else $error("result dropped or changed under stall");
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("controller not busy after accept");
	a_free_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid && !in_stall)
		else $error("not idle after result taken");
endmodule

bind factorial_divisibility_test_top fdt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .divides(divides)
);
`default_nettype wire
